### rtl/morse_text_codec_top_assert.svh
// Assertion macros used by the checker of the Morse codec.
`ifndef MORSE_TEXT_CODEC_TOP_ASSERT_SVH
`define MORSE_TEXT_CODEC_TOP_ASSERT_SVH

// Clocked assertion that is ignored while reset is asserted.
`define MTC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define MTC_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/mtc_pkg.sv
package mtc_pkg;

    // Most result bytes that one input item can cause.
    localparam int MaxOut = 8;
    // Longest Morse code in elements.
    localparam int CodeMax = 5;
    // Number of table entries that map to a character.
    localparam int CharCount = 36;
    localparam int LetterCount = 26;
    // Depth of the job queue between front and back; a power of two.
    localparam int QDepth = 4;
    localparam int QPtrW = $clog2(QDepth);

    // ASCII codes used by the codec.
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_BAR   = 8'h7C;
    localparam logic [7:0] CH_A     = 8'h61;
    localparam logic [7:0] CH_Z     = 8'h7A;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_stream;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_of_run;
    } out_item_t;

    // A Morse code: element k sits in bit k of dashes, 1 means dash.
    typedef struct packed {
        logic [2:0] len;
        logic [4:0] dashes;
    } code_t;

    // A job for the back end: the result bytes of one input item, in order.
    typedef struct packed {
        logic [3:0]             count;
        logic [MaxOut-1:0][7:0] bytes;
    } job_t;

    // Queue status seen by the back end.
    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    // Codes for 'a'..'z' followed by '0'..'9'.
    localparam code_t SYM_TABLE [CharCount] = '{
        '{3'd2, 5'b00010}, '{3'd4, 5'b00001}, '{3'd4, 5'b00101}, '{3'd3, 5'b00001},
        '{3'd1, 5'b00000}, '{3'd4, 5'b00100}, '{3'd3, 5'b00011}, '{3'd4, 5'b00000},
        '{3'd2, 5'b00000}, '{3'd4, 5'b01110}, '{3'd3, 5'b00101}, '{3'd4, 5'b00010},
        '{3'd2, 5'b00011}, '{3'd2, 5'b00001}, '{3'd3, 5'b00111}, '{3'd4, 5'b00110},
        '{3'd4, 5'b01011}, '{3'd3, 5'b00010}, '{3'd3, 5'b00000}, '{3'd1, 5'b00001},
        '{3'd3, 5'b00100}, '{3'd4, 5'b01000}, '{3'd3, 5'b00110}, '{3'd4, 5'b01001},
        '{3'd4, 5'b01101}, '{3'd4, 5'b00011},
        '{3'd5, 5'b11111}, '{3'd5, 5'b11110}, '{3'd5, 5'b11100}, '{3'd5, 5'b11000},
        '{3'd5, 5'b10000}, '{3'd5, 5'b00000}, '{3'd5, 5'b00001}, '{3'd5, 5'b00011},
        '{3'd5, 5'b00111}, '{3'd5, 5'b01111}
    };

    // Looks up the code of a text byte; the top bit flags a letter or digit.
    function automatic logic [8:0] encode_code(input logic [7:0] b);
        logic [5:0] idx;
        logic       hit;
        idx = '0;
        hit = 1'b0;
        if (b inside {[CH_A:CH_Z]}) begin
            idx = 6'(b - CH_A);
            hit = 1'b1;
        end
        else if (b inside {[CH_0:CH_9]}) begin
            idx = 6'(b - CH_0) + 6'(LetterCount);
            hit = 1'b1;
        end
        return {hit, SYM_TABLE[idx]};
    endfunction

    // Finds the character of a code; the top bit flags a match.
    function automatic logic [8:0] decode_char(input code_t c);
        logic       found;
        logic [7:0] ch;
        found = 1'b0;
        ch = '0;
        for (int i = 0; i < CharCount; i++) begin
            if (SYM_TABLE[i] == c) begin
                found = 1'b1;
                if (i < LetterCount) begin
                    ch = ch | (CH_A + 8'(i));
                end
                else begin
                    ch = ch | (CH_0 + 8'(i - LetterCount));
                end
            end
        end
        return {found, ch};
    endfunction

endpackage

### rtl/mtc_front.sv
module mtc_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic              cfg_data,
    input  logic              accept,
    input  mtc_pkg::in_item_t in_item,
    output logic              job_push,
    output mtc_pkg::job_t     job
);

    logic       decode_mode_reg;
    logic [4:0] elems_reg, elems_next;
    logic [2:0] len_reg, len_next;
    logic       inval_reg, inval_next;
    logic       seg_reg, seg_next;
    logic [8:0] enc;
    logic [7:0] dash8;
    logic [8:0] dec_a;
    logic [8:0] dec_b;
    logic       is_elem;
    logic [4:0] elems_app;
    logic [2:0] len_app;

    // Text byte to its Morse code.
    assign enc   = mtc_pkg::encode_code(in_item.in_byte);
    assign dash8 = {3'b000, enc[4:0]};
    assign is_elem = in_item.in_byte inside {mtc_pkg::CH_DOT, mtc_pkg::CH_DASH};

    // The pending code with the current element appended.
    assign len_app   = len_reg + 3'd1;
    assign elems_app = elems_reg |
                       ((in_item.in_byte == mtc_pkg::CH_DASH) ? (5'b00001 << len_reg) : 5'b00000);

    // Character lookups for a code ended by the byte itself and by the end of stream.
    // Only an element byte leaves a code pending for the end of stream to close.
    assign dec_a = mtc_pkg::decode_char({len_reg, elems_reg});
    assign dec_b = mtc_pkg::decode_char({len_app, elems_app});

    // Classify the item, update the decoder state and build the result bytes.
    always_comb
    begin
        elems_next = elems_reg;
        len_next   = len_reg;
        inval_next = inval_reg;
        seg_next   = seg_reg;
        job.count  = '0;
        job.bytes  = '0;
        if (!decode_mode_reg) begin
            if (in_item.in_byte == mtc_pkg::CH_SPACE) begin
                for (int k = 0; k < mtc_pkg::MaxOut; k++) begin
                    job.bytes[k] = (k == 1) ? mtc_pkg::CH_BAR : mtc_pkg::CH_SPACE;
                end
                job.count = 4'd5;
            end
            else if (enc[8]) begin
                for (int k = 0; k < mtc_pkg::MaxOut; k++) begin
                    if (3'(k) < enc[7:5] && k < mtc_pkg::CodeMax) begin
                        job.bytes[k] = dash8[k] ? mtc_pkg::CH_DASH : mtc_pkg::CH_DOT;
                    end
                    else begin
                        job.bytes[k] = mtc_pkg::CH_SPACE;
                    end
                end
                job.count = {1'b0, enc[7:5]} + 4'd3;
            end
        end
        else begin
            if (is_elem) begin
                seg_next = 1'b1;
                if (len_reg < 3'(mtc_pkg::CodeMax)) begin
                    elems_next = elems_app;
                    len_next   = len_app;
                end
                else begin
                    inval_next = 1'b1;
                end
            end
            else if (in_item.in_byte inside {mtc_pkg::CH_SPACE, mtc_pkg::CH_BAR}) begin
                // The pending code ends here.
                if (!inval_reg && len_reg != 3'd0 && dec_a[8]) begin
                    job.bytes[0] = dec_a[7:0];
                    job.count    = 4'd1;
                end
                elems_next = '0;
                len_next   = '0;
                inval_next = 1'b0;
                if (in_item.in_byte == mtc_pkg::CH_SPACE) begin
                    seg_next = 1'b1;
                end
                else begin
                    if (seg_reg) begin
                        job.bytes[job.count[2:0]] = mtc_pkg::CH_SPACE;
                        job.count = job.count + 4'd1;
                    end
                    seg_next = 1'b0;
                end
            end
            else begin
                seg_next   = 1'b1;
                inval_next = 1'b1;
            end
            // End of stream closes the code and the segment after the byte.
            if (in_item.end_of_stream) begin
                if (!inval_next && len_next != 3'd0 && dec_b[8]) begin
                    job.bytes[job.count[2:0]] = dec_b[7:0];
                    job.count = job.count + 4'd1;
                end
                if (seg_next) begin
                    job.bytes[job.count[2:0]] = mtc_pkg::CH_SPACE;
                    job.count = job.count + 4'd1;
                end
                elems_next = '0;
                len_next   = '0;
                inval_next = 1'b0;
                seg_next   = 1'b0;
            end
        end
    end

    // Items that cause no result are not queued.
    assign job_push = accept && (job.count != 4'd0);

    // Mode register and decoder state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            decode_mode_reg <= 1'b0;
            elems_reg       <= '0;
            len_reg         <= '0;
            inval_reg       <= 1'b0;
            seg_reg         <= 1'b0;
        end
        else begin
            if (cfg_we) begin
                decode_mode_reg <= cfg_data;
            end
            if (accept) begin
                elems_reg <= elems_next;
                len_reg   <= len_next;
                inval_reg <= inval_next;
                seg_reg   <= seg_next;
            end
        end
    end

endmodule

### rtl/mtc_fifo.sv
module mtc_fifo (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                wr_en,
    input  mtc_pkg::job_t       wr_data,
    input  logic                rd_en,
    output mtc_pkg::job_t       rd_data,
    output mtc_pkg::q_status_t  status
);

    mtc_pkg::job_t                mem_reg [mtc_pkg::QDepth];
    logic [mtc_pkg::QPtrW-1:0]    wr_ptr_reg;
    logic [mtc_pkg::QPtrW-1:0]    rd_ptr_reg;
    logic [mtc_pkg::QPtrW:0]      count_reg;
    logic                         do_wr;
    logic                         do_rd;

    assign status.full  = (count_reg == (mtc_pkg::QPtrW + 1)'(mtc_pkg::QDepth));
    assign status.empty = (count_reg == '0);
    assign do_wr = wr_en && !status.full;
    assign do_rd = rd_en && !status.empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    // Job storage.
    always_ff @(posedge clk)
    begin
        if (do_wr) begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    // Pointers and fill level.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else begin
            if (do_wr) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_rd) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_wr && !do_rd) begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_rd && !do_wr) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

### rtl/mtc_back.sv
module mtc_back (
    input  logic                clk,
    input  logic                rst_n,
    input  mtc_pkg::q_status_t  q_status,
    input  mtc_pkg::job_t       q_data,
    output logic                q_pop,
    input  logic                pop,
    output logic                empty,
    output mtc_pkg::out_item_t  out_item
);

    mtc_pkg::job_t      job_reg, job_next;
    logic               job_valid_reg, job_valid_next;
    logic [2:0]         idx_reg, idx_next;
    logic               out_valid_reg, out_valid_next;
    mtc_pkg::out_item_t out_reg, out_next;
    logic               take;
    logic               advance;
    logic               job_last;
    logic               need_job;

    // The output register frees when empty or when its result transfers.
    assign take     = !out_valid_reg || pop;
    assign advance  = take && job_valid_reg;
    assign job_last = (idx_reg == 3'(job_reg.count - 4'd1));
    assign need_job = !job_valid_reg || (advance && job_last);
    assign q_pop    = need_job && !q_status.empty;

    // Step through the current job one byte per cycle while the output register is free to take it.
    always_comb
    begin
        job_next       = job_reg;
        job_valid_next = job_valid_reg;
        idx_next       = idx_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        if (advance) begin
            out_next.out_byte    = job_reg.bytes[idx_reg];
            out_next.last_of_run = job_last;
            out_valid_next       = 1'b1;
        end
        else if (take) begin
            out_valid_next = 1'b0;
        end
        if (need_job) begin
            job_next       = q_data;
            job_valid_next = !q_status.empty;
            idx_next       = '0;
        end
        else if (advance) begin
            idx_next = idx_reg + 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            job_valid_reg <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else begin
            job_valid_reg <= job_valid_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        job_reg <= job_next;
        out_reg <= out_next;
    end

    assign empty    = !out_valid_reg;
    assign out_item = out_reg;

endmodule

### rtl/morse_text_codec_top.sv
// The first result of an item passes through the job queue, the back end's job register and its output register.
// The front accepts one input item per cycle while the queue is not full; the back end sends one
// result byte per cycle while the receiver pops results, and an item causes up to 8 results.
// A four-entry job queue lets the front keep accepting while the back end drains.
// Reset (rst_n low, asynchronous) clears the mode to encode, the decoder state and the queue.
module morse_text_codec_top (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  mtc_pkg::in_item_t  in_item,
    output logic               empty,
    input  logic               pop,
    output mtc_pkg::out_item_t out_item,
    input  logic               cfg_we,
    input  logic               cfg_data
);

    mtc_pkg::job_t      wr_job;
    mtc_pkg::job_t      rd_job;
    mtc_pkg::q_status_t q_status;
    logic               job_push;
    logic               q_pop;
    logic               accept;

    // An item transfers when it is pushed and the queue has room.
    assign full   = q_status.full;
    assign accept = push && !q_status.full;

    mtc_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .accept   (accept),
        .in_item  (in_item),
        .job_push (job_push),
        .job      (wr_job)
    );

    mtc_fifo u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (job_push),
        .wr_data (wr_job),
        .rd_en   (q_pop),
        .rd_data (rd_job),
        .status  (q_status)
    );

    mtc_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_status (q_status),
        .q_data   (rd_job),
        .q_pop    (q_pop),
        .pop      (pop),
        .empty    (empty),
        .out_item (out_item)
    );

endmodule

### rtl/mtc_checker.sv
`include "morse_text_codec_top_assert.svh"

module mtc_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               empty,
    input logic               pop,
    input mtc_pkg::out_item_t out_item
);

    logic legal_byte;
    logic bar_out;

    // Every result byte is a Morse symbol, a separator or a decoded character.
    assign legal_byte = out_item.out_byte inside {mtc_pkg::CH_DOT, mtc_pkg::CH_DASH,
                                                  mtc_pkg::CH_SPACE, mtc_pkg::CH_BAR,
                                                  [mtc_pkg::CH_A:mtc_pkg::CH_Z],
                                                  [mtc_pkg::CH_0:mtc_pkg::CH_9]};

    // A waiting result that is the bar of a word space.
    assign bar_out = !empty && (out_item.out_byte == mtc_pkg::CH_BAR);

    // A waiting result stays until it transfers.
    `MTC_ASSERT(a_hold, (!empty && !pop) |=> (!empty && $stable(out_item)), "result dropped")

    // Nothing waits on the result side right after reset.
    `MTC_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> empty, "result after reset")

    `MTC_ASSERT(a_legal, !empty |-> legal_byte, "illegal result byte")

    // The bar of a word space never ends a run, since three spaces follow it.
    `MTC_ASSERT(a_bar_not_last, bar_out |-> !out_item.last_of_run, "bar ends a run")

endmodule

bind morse_text_codec_top mtc_checker u_mtc_checker (.*);
